FILE: hdl/kbfs_pkg.sv
// ----------------------------------------------------------------------------
// kbfs_pkg
// Shared types, constants and move tables for the knight minimum-move search.
// ----------------------------------------------------------------------------
package kbfs_pkg;

	localparam int MAX_SIDE_DEF = 32;
	localparam int COORD_W      = 6;
	localparam int COUNT_W      = 10;
	localparam logic [COORD_W-1:0] BOARD_SIZE_RST = 6'd8;

	// input transfer: one query
	typedef struct packed {
		logic [COORD_W-1:0] start_row;
		logic [COORD_W-1:0] start_col;
		logic [COORD_W-1:0] target_row;
		logic [COORD_W-1:0] target_col;
	} in_item_t;

	// output transfer: one answer
	typedef struct packed {
		logic [COUNT_W-1:0] move_count;
		logic               found;
	} out_item_t;

	// frontier queue entry: square and its move count from the start
	typedef struct packed {
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic [COUNT_W-1:0] hops;
	} qent_t;

	typedef enum logic [1:0] {
		RES_KEEP,
		RES_MISS,
		RES_SAME,
		RES_HIT
	} res_kind_t;

	// controller -> datapath
	typedef struct packed {
		logic      load;
		logic      clr;
		logic      seed;
		logic      pop;
		logic      latch;
		logic      nb_rd;
		logic      nb_mark;
		logic      enq;
		logic      k_inc;
		res_kind_t res;
		logic      out_load;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic bad;
		logic same;
		logic clr_last;
		logic q_empty;
		logic on_board;
		logic visited;
		logic is_target;
		logic k_last;
		logic out_busy;
	} sts_t;

	// knight move table, order (+2,+1) (+2,-1) (-2,+1) (-2,-1) (+1,+2) (-1,+2) (+1,-2) (-1,-2)
	function automatic logic signed [7:0] step_dr(input logic [2:0] k);
		logic signed [7:0] r;
		unique case (k)
			3'd0, 3'd1: r = 8'sd2;
			3'd2, 3'd3: r = -8'sd2;
			3'd4, 3'd6: r = 8'sd1;
			default:    r = -8'sd1;
		endcase
		return r;
	endfunction

	function automatic logic signed [7:0] step_dc(input logic [2:0] k);
		logic signed [7:0] r;
		unique case (k)
			3'd0, 3'd2: r = 8'sd1;
			3'd1, 3'd3: r = -8'sd1;
			3'd4, 3'd5: r = 8'sd2;
			default:    r = -8'sd2;
		endcase
		return r;
	endfunction

endpackage

FILE: hdl/knight_shortest_path_bfs.sv
// ----------------------------------------------------------------------------
// knight_shortest_path_bfs
// Fewest knight moves between two squares on a configurable square board,
// found by breadth-first search with a queue and a visited map in RAM.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid / in_stall   | in_item_t (start, target)
//   out     | output    | out_valid / out_stall | out_item_t (move_count, found)
//   cfg     | input     | cfg_we                | cfg_wdata = board_size
//
// Off-board or identical squares are answered without a search.
// A search first clears the visited map, all MAX_SIDE*MAX_SIDE squares.
// Then each dequeued square is popped and latched; each knight move is checked
// against the board and, if on it, looked up in the visited map's single read port.
// One query at a time; in_stall is high from transfer to answer handoff.
// The answer waits in an output register while out_stall is high.
// ----------------------------------------------------------------------------
module knight_shortest_path_bfs import kbfs_pkg::*; #(
	parameter int MAX_SIDE = MAX_SIDE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [COORD_W-1:0] cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  in_item_t           in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output out_item_t          out_data
);

	cmd_t cmd;
	sts_t sts;

	kbfs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	kbfs_dp #(.MAX_SIDE(MAX_SIDE)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

FILE: hdl/kbfs_ram.sv
// ----------------------------------------------------------------------------
// kbfs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module kbfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hdl/kbfs_dp.sv
// ----------------------------------------------------------------------------
// kbfs_dp
// Search datapath: board register, query, visited map, frontier queue,
// neighbor generation and the output register.
// ----------------------------------------------------------------------------
module kbfs_dp import kbfs_pkg::*; #(
	parameter int MAX_SIDE = MAX_SIDE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [COORD_W-1:0] cfg_wdata,
	input  in_item_t           in_data,
	input  logic               out_stall,
	output logic               out_valid,
	output out_item_t          out_data,
	input  cmd_t               cmd,
	output sts_t               sts
);

	localparam int SQUARES = MAX_SIDE * MAX_SIDE;
	localparam int IW      = (SQUARES > 1) ? $clog2(SQUARES) : 1;
	localparam logic [6:0]  SIDE_MAX = 7'(MAX_SIDE);
	localparam logic [IW:0] SQ_END   = (IW+1)'(SQUARES);

	logic [COORD_W-1:0] board_size_q;
	in_item_t           qry_q;
	logic [IW-1:0]      clr_q;
	logic [IW:0]        head_q, tail_q;
	qent_t              cur_q;
	logic [2:0]         k_q;
	logic [IW-1:0]      nxt_q;
	logic [COORD_W-1:0] nr_q, nc_q;
	logic               tgt_q;
	logic [COUNT_W-1:0] res_count_q;
	logic               res_found_q;
	logic               out_valid_q;
	out_item_t          out_data_q;

	logic [6:0]         side;
	logic signed [7:0]  nr, nc, side_s;
	logic [IW-1:0]      nb_idx, first_idx;
	logic               v_we, v_wdata, v_rdata;
	logic [IW-1:0]      v_waddr;
	logic               q_we;
	logic [IW-1:0]      q_waddr;
	qent_t              q_wdata, q_rdata;

	// effective board side
	assign side   = ({1'b0, board_size_q} > SIDE_MAX) ? SIDE_MAX : {1'b0, board_size_q};
	assign side_s = $signed({1'b0, side});

	// neighbor of the current square for move k
	assign nr = $signed({2'b00, cur_q.row}) + step_dr(k_q);
	assign nc = $signed({2'b00, cur_q.col}) + step_dc(k_q);
	assign nb_idx = IW'(({26'd0, nr[5:0]} - 32'd1) * 32'(MAX_SIDE)
		+ ({26'd0, nc[5:0]} - 32'd1));
	assign first_idx = IW'(({26'd0, qry_q.start_row} - 32'd1) * 32'(MAX_SIDE)
		+ ({26'd0, qry_q.start_col} - 32'd1));

	// status
	always_comb begin
		sts.bad = (qry_q.start_row == '0) || ({1'b0, qry_q.start_row} > side)
			|| (qry_q.start_col == '0) || ({1'b0, qry_q.start_col} > side)
			|| (qry_q.target_row == '0) || ({1'b0, qry_q.target_row} > side)
			|| (qry_q.target_col == '0) || ({1'b0, qry_q.target_col} > side);
		sts.same      = (qry_q.start_row == qry_q.target_row)
			&& (qry_q.start_col == qry_q.target_col);
		sts.clr_last  = (clr_q == IW'(SQUARES - 1));
		sts.q_empty   = (head_q == tail_q) || (head_q == SQ_END);
		sts.on_board  = (nr >= 8'sd1) && (nc >= 8'sd1) && (nr <= side_s) && (nc <= side_s);
		sts.visited   = v_rdata;
		sts.is_target = tgt_q;
		sts.k_last    = (k_q == 3'd7);
		sts.out_busy  = out_valid_q && out_stall;
	end

	// visited map ports
	assign v_we    = cmd.clr || cmd.seed || cmd.nb_mark;
	assign v_wdata = !cmd.clr;
	assign v_waddr = cmd.clr ? clr_q : (cmd.seed ? first_idx : nxt_q);

	kbfs_ram #(.WIDTH(1), .DEPTH(SQUARES), .AW(IW)) u_visited (
		.clk   (clk),
		.we    (v_we),
		.waddr (v_waddr),
		.wdata (v_wdata),
		.raddr (nb_idx),
		.rdata (v_rdata)
	);

	// frontier queue ports
	assign q_we    = cmd.seed || (cmd.enq && (tail_q < SQ_END));
	assign q_waddr = cmd.seed ? '0 : tail_q[IW-1:0];
	always_comb begin
		if (cmd.seed) begin
			q_wdata = '{row: qry_q.start_row, col: qry_q.start_col, hops: '0};
		end else begin
			q_wdata = '{row: nr_q, col: nc_q, hops: cur_q.hops + 10'd1};
		end
	end

	kbfs_ram #(.WIDTH($bits(qent_t)), .DEPTH(SQUARES), .AW(IW)) u_queue (
		.clk   (clk),
		.we    (q_we),
		.waddr (q_waddr),
		.wdata (q_wdata),
		.raddr (head_q[IW-1:0]),
		.rdata (q_rdata)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			board_size_q <= BOARD_SIZE_RST;
			clr_q        <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			k_q          <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				board_size_q <= cfg_wdata;
			end
			if (cmd.load) begin
				clr_q <= '0;
			end else if (cmd.clr) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.seed) begin
				head_q <= '0;
				tail_q <= (IW+1)'(1);
			end else begin
				if (cmd.pop) begin
					head_q <= head_q + 1'b1;
				end
				if (q_we) begin
					tail_q <= tail_q + 1'b1;
				end
			end
			if (cmd.latch) begin
				k_q <= '0;
			end else if (cmd.k_inc) begin
				k_q <= k_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			qry_q <= in_data;
		end
		if (cmd.latch) begin
			cur_q <= q_rdata;
		end
		if (cmd.nb_rd) begin
			nxt_q <= nb_idx;
			nr_q  <= nr[5:0];
			nc_q  <= nc[5:0];
			tgt_q <= (nr[5:0] == qry_q.target_row) && (nc[5:0] == qry_q.target_col);
		end
		unique case (cmd.res)
			RES_MISS: begin
				res_count_q <= '0;
				res_found_q <= 1'b0;
			end
			RES_SAME: begin
				res_count_q <= '0;
				res_found_q <= 1'b1;
			end
			RES_HIT: begin
				res_count_q <= cur_q.hops + 10'd1;
				res_found_q <= 1'b1;
			end
			RES_KEEP: begin
			end
		endcase
		if (cmd.out_load) begin
			out_data_q <= '{move_count: res_count_q, found: res_found_q};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// queue pointers stay ordered and bounded
	a_head_le_tail: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= tail_q) else $error("queue head passed tail");
	a_tail_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tail_q <= SQ_END) else $error("queue tail beyond board");
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_data_q.found |-> out_data_q.move_count == '0)
		else $error("not-found answer with nonzero count");

endmodule

FILE: hdl/kbfs_ctrl.sv
// ----------------------------------------------------------------------------
// kbfs_ctrl
// Search sequencer: clears the visited map, seeds the queue, pops squares
// and walks their eight knight moves, then hands the answer out.
// ----------------------------------------------------------------------------
module kbfs_ctrl import kbfs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_CLEAR,
		S_SEED,
		S_POP,
		S_POPW,
		S_NB,
		S_NBCHK,
		S_DONE
	} state_t;

	state_t state_q;

	assign in_stall = (state_q != S_IDLE);

	// commands for the current state
	always_comb begin
		cmd = '0;
		cmd.res = RES_KEEP;
		unique case (state_q)
			S_IDLE:  cmd.load = in_valid;
			S_CHECK: begin
				if (sts.bad) begin
					cmd.res = RES_MISS;
				end else if (sts.same) begin
					cmd.res = RES_SAME;
				end
			end
			S_CLEAR: cmd.clr  = 1'b1;
			S_SEED:  cmd.seed = 1'b1;
			S_POP: begin
				if (sts.q_empty) begin
					cmd.res = RES_MISS;
				end else begin
					cmd.pop = 1'b1;
				end
			end
			S_POPW:  cmd.latch = 1'b1;
			S_NB: begin
				if (sts.on_board) begin
					cmd.nb_rd = 1'b1;
				end else begin
					cmd.k_inc = 1'b1;
				end
			end
			S_NBCHK: begin
				if (!sts.visited) begin
					cmd.nb_mark = 1'b1;
					if (sts.is_target) begin
						cmd.res = RES_HIT;
					end else begin
						cmd.enq = 1'b1;
					end
				end
				cmd.k_inc = sts.visited || !sts.is_target;
			end
			S_DONE:  cmd.out_load = !sts.out_busy;
			default: cmd = '0;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE:  if (in_valid) state_q <= S_CHECK;
				S_CHECK: state_q <= (sts.bad || sts.same) ? S_DONE : S_CLEAR;
				S_CLEAR: if (sts.clr_last) state_q <= S_SEED;
				S_SEED:  state_q <= S_POP;
				S_POP:   state_q <= sts.q_empty ? S_DONE : S_POPW;
				S_POPW:  state_q <= S_NB;
				S_NB: begin
					if (sts.on_board) begin
						state_q <= S_NBCHK;
					end else if (sts.k_last) begin
						state_q <= S_POP;
					end
				end
				S_NBCHK: begin
					if (!sts.visited && sts.is_target) begin
						state_q <= S_DONE;
					end else begin
						state_q <= sts.k_last ? S_POP : S_NB;
					end
				end
				S_DONE:  if (!sts.out_busy) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// an answer is only handed out when the output register is free
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !sts.out_busy) else $error("answer overwrote pending output");
	// a query is only taken while idle
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == S_CHECK) else $error("query taken outside idle");
	// the map is never cleared and marked in one cycle
	a_clr_mark: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.clr && (cmd.nb_mark || cmd.seed))) else $error("clear overlaps mark");

endmodule

FILE: bench/knight_shortest_path_bfs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knight_shortest_path_bfs_checker
// Watches the query and answer channels of the knight search, works out the
// fewest knight moves for every accepted query and compares the answers.
// ----------------------------------------------------------------------------
module knight_shortest_path_bfs_checker import kbfs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [COORD_W-1:0] cfg_wdata,
	input  logic               in_valid,
	input  logic               in_stall,
	input  in_item_t           in_data,
	input  logic               out_valid,
	input  logic               out_stall,
	input  out_item_t          out_data,
	output int                 fail_count,
	output int                 pending,
	output int                 answers_seen
);

	logic [COORD_W-1:0] board_side;
	out_item_t          answer_q[$];
	int                 mismatches;

	// breadth-first search over knight moves, move counts per square
	function automatic out_item_t solve_knight(input logic [COORD_W-1:0] bsz, input in_item_t q);
		int side, sr, sc, tr, tc, head, tail, cur, r, c, nr, nc, nx;
		int hops[1024];
		bit seen[1024];
		int fifo[1024];
		int dr[8], dc[8];
		out_item_t res;
		dr = '{2, 2, -2, -2, 1, -1, 1, -1};
		dc = '{1, -1, 1, -1, 2, 2, -2, -2};
		side = (bsz > 32) ? 32 : bsz;
		sr = q.start_row; sc = q.start_col; tr = q.target_row; tc = q.target_col;
		res = '0;
		if (sr < 1 || sr > side || sc < 1 || sc > side ||
		    tr < 1 || tr > side || tc < 1 || tc > side) return res;
		if (sr == tr && sc == tc) begin
			res.found = 1'b1;
			return res;
		end
		head = 0; tail = 1;
		fifo[0] = (sr - 1) * 32 + sc - 1;
		seen[fifo[0]] = 1; hops[fifo[0]] = 0;
		while (head < tail) begin
			cur = fifo[head];
			head++;
			r = cur / 32 + 1; c = cur % 32 + 1;
			for (int k = 0; k < 8; k++) begin
				nr = r + dr[k]; nc = c + dc[k];
				if (nr < 1 || nc < 1 || nr > side || nc > side) continue;
				nx = (nr - 1) * 32 + nc - 1;
				if (seen[nx]) continue;
				seen[nx] = 1;
				hops[nx] = (hops[cur] + 1) & 10'h3FF;
				if (nr == tr && nc == tc) begin
					res.move_count = 10'(hops[nx]);
					res.found = 1'b1;
					return res;
				end
				fifo[tail] = nx;
				tail++;
			end
		end
		return res;
	endfunction

	assign pending = answer_q.size();
	assign fail_count = mismatches;

	// track config, predict on query transfer, compare on answer transfer
	always @(posedge clk or negedge arst_n) begin
		out_item_t exp_ans;
		if (!arst_n) begin
			board_side <= BOARD_SIZE_RST;
			mismatches = 0;
			answers_seen = 0;
		end else begin
			if (cfg_we) board_side <= cfg_wdata;
			if (in_valid && !in_stall) answer_q = {answer_q, solve_knight(board_side, in_data)};
			if (out_valid && !out_stall) begin
				answers_seen++;
				if (answer_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected answer %0d/%0d",
						out_data.move_count, out_data.found);
				end else begin
					exp_ans = answer_q.pop_front();
					if (exp_ans.move_count !== out_data.move_count ||
					    exp_ans.found !== out_data.found) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected moves %0d found %0d, got moves %0d found %0d",
								exp_ans.move_count, exp_ans.found,
								out_data.move_count, out_data.found);
					end
				end
			end
		end
	end

endmodule

FILE: bench/knight_shortest_path_bfs_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knight_shortest_path_bfs_test
// Drives queries and board sizes into the knight search and gives the verdict;
// the checker beside the block predicts and compares every answer.
// ----------------------------------------------------------------------------
module knight_shortest_path_bfs_test;
	import kbfs_pkg::*;

	localparam int WATCHDOG = 200000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [COORD_W-1:0] cfg_wdata = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	in_item_t           in_data = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	out_item_t          out_data;
	int                 fail_count, pending, answers_seen;
	int                 send_idle_pct, recv_idle_pct, hold_cycles, idle_cycles, queries;

	always #4 clk = ~clk;

	knight_shortest_path_bfs dut (.*);
	knight_shortest_path_bfs_checker chk (.*);

	// receiver: random stall, or a long hold-off when requested
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("simulation failed");
			$finish;
		end
	end

	// valid stays high after a transfer until the next idle cycle or query
	task automatic send_query(input int sr, input int sc, input int tr, input int tc);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{sr[5:0], sc[5:0], tr[5:0], tc[5:0]};
		@(posedge clk);
		while (in_stall) @(posedge clk);
		queries++;
	endtask

	task automatic set_board(input int side);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= side[5:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_random(input int n, input int side);
		int lim;
		lim = (side < 1) ? 1 : (side > 32 ? 32 : side);
		repeat (n) begin
			if ($urandom_range(9) == 0)
				send_query($urandom_range(63), $urandom_range(63),
					$urandom_range(63), $urandom_range(63));
			else
				send_query($urandom_range(lim, 1), $urandom_range(lim, 1),
					$urandom_range(lim, 1), $urandom_range(lim, 1));
		end
	endtask

	initial begin
		hold_cycles = 0; idle_cycles = 0; queries = 0;
		send_idle_pct = 36; recv_idle_pct = 81;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset board, corners, same square, off-board, field extremes
		send_query(1, 1, 8, 8);
		send_query(1, 1, 2, 2);
		send_query(4, 4, 4, 4);
		send_query(0, 1, 2, 3);
		send_query(1, 9, 2, 3);
		send_query(63, 63, 63, 63);
		send_query(8, 8, 1, 1);
		set_board(1);
		send_query(1, 1, 1, 1);
		send_query(1, 1, 1, 2);
		set_board(2);
		send_query(1, 1, 2, 2);
		set_board(3);
		send_query(1, 1, 2, 2);
		send_query(1, 1, 3, 3);
		set_board(0);
		send_query(1, 1, 1, 1);
		set_board(63);
		send_query(1, 1, 32, 32);
		send_query(32, 32, 1, 1);
		send_query(33, 1, 1, 1);
		set_board(32);
		send_query(1, 1, 32, 31);
		send_query(16, 16, 16, 16);

		// random part with long receiver hold-off at the start
		set_board(5);
		hold_cycles = 3000;
		send_random(30, 5);
		send_idle_pct = 81; recv_idle_pct = 36;
		set_board(8);
		send_random(30, 8);
		send_idle_pct = 0; recv_idle_pct = 0;
		set_board(4);
		send_random(15, 4);
		set_board(32);
		send_random(10, 32);
		set_board(63);
		send_random(5, 32);

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("ran %0d queries, %0d answers, board sides 0 to 63 incl. off-board squares",
			queries, answers_seen);
		if (fail_count == 0) $display("simulation ok");
		else $display("simulation failed");
		$finish;
	end

endmodule
